>>> design/pcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared widths, defaults and the controller state type of the precedence
// closure and cycle check block.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int ROW_W         = 64;  // width of one adjacency row
  localparam int ROW_INDEX_W   = 6;   // width of the row index field
  localparam int COUNT_W       = 7;   // width of the item count register
  localparam int MAX_ITEMS_DEF = 64;  // default upper bound on the item count
  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

  typedef enum logic [3:0] {
    ST_LOAD,       // idle, taking rows
    ST_PIV_RD,     // read the pivot row
    ST_PIV_CAP,    // capture the pivot row
    ST_SWEEP,      // read each row, update the one read before
    ST_SWEEP_END,  // finish the last update of a pass
    ST_CHECK,      // read rows and test diagonal bits
    ST_CHECK_END,  // test the last diagonal bit, report a cycle
    ST_EMIT,       // read rows and present them as results
    ST_EMIT_END    // present the last row
  } pcc_state_t;

endpackage : pcc_pkg
`default_nettype wire

>>> design/pcc_row_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcc_row_mem
// Row store: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pcc_row_mem #(
  parameter int DEPTH  = pcc_pkg::MAX_ITEMS_DEF,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = pcc_pkg::ROW_W
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the entry written in the same cycle returns the old contents;
  // the controller never issues one.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : pcc_row_mem
`default_nettype wire

>>> design/precedence_closure_cycle_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// precedence_closure_cycle_check
// Loads the rows of a boolean precedence matrix, builds its transitive
// closure with a Warshall sweep over a row memory, and reports either every
// closed row or a single cycle result.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  --------  ----------------------  -------------------------------------------
//  input     start & !busy           row_bits
//  result    done (one cycle)        row_index, closed_row, cycle_found,
//                                    last_result
//  config    cfg_we                  cfg_data (item count)
//
// A row is taken when start is high and busy is low. Each of the first n-1 rows
// of a run produces nothing. After the n-th row the block is busy for the
// closure (per pivot: a pivot read, a capture, a read of every row and a step
// to finish the last write-back), then for the diagonal check (a read of every
// row and a final test), then, for an acyclic graph, for reading the closed
// rows. A cycle result appears in the same cycle as busy falls. The n
// closed rows follow one per cycle, each through the memory read register and
// the result registers; the last one also appears in the same cycle as
// busy falls. The single memory read port, one row per cycle, sets the length
// of each phase. Reset is synchronous and active high; it clears the controller
// and the item count (to 64) but not the row memory. Results cannot be
// stalled; a transfer happens in every cycle that done is high.
// ----------------------------------------------------------------------------
module precedence_closure_cycle_check #(
  parameter int MAX_ITEMS = pcc_pkg::MAX_ITEMS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // Input rows
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [pcc_pkg::ROW_W-1:0]           row_bits,
  // Item count register
  input  wire logic                                cfg_we,
  input  wire logic [pcc_pkg::COUNT_W-1:0]         cfg_data,
  // Results
  output logic                                     done,
  output logic      [pcc_pkg::ROW_INDEX_W-1:0]     row_index,
  output logic      [pcc_pkg::ROW_W-1:0]           closed_row,
  output logic                                     cycle_found,
  output logic                                     last_result
);

  import pcc_pkg::*;

  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  pcc_state_t state, state_next;

  logic [COUNT_W-1:0] item_count;
  logic [CNT_W-1:0]   n_act;      // item count clamped to 1..MAX_ITEMS
  logic [CNT_W-1:0]   n_m1;
  logic [CNT_W-1:0]   rows_loaded;
  logic [CNT_W-1:0]   idx;        // scan read pointer
  logic [CNT_W-1:0]   k;          // pivot
  logic [ROW_INDEX_W-1:0] k_bit;
  logic [ROW_W-1:0]   col_mask;
  logic [ROW_W-1:0]   pivot;
  logic               p_valid;    // read data of row p_idx arrives this cycle
  logic [IDX_W-1:0]   p_idx;
  logic               cyc;
  logic               diag_hit;
  logic               cyc_now;
  logic               accept;
  logic               last_row;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ROW_W-1:0]   wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ROW_W-1:0]   rd_data;

  // Clamp the register value to the supported range of items.
  always_comb begin
    if (item_count == '0) begin
      n_act = CNT_W'(1);
    end else if (item_count > COUNT_W'(MAX_ITEMS)) begin
      n_act = CNT_W'(MAX_ITEMS);
    end else begin
      n_act = CNT_W'(item_count);
    end
    n_m1 = n_act - CNT_W'(1);
  end

  // Columns at or above the item count are dropped when a row is stored.
  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      col_mask[j] = (COUNT_W'(j) < COUNT_W'(n_act));
    end
  end

  assign busy     = (state != ST_LOAD);
  assign accept   = start && !busy;
  assign last_row = (rows_loaded == n_m1);
  assign k_bit    = ROW_INDEX_W'(k);
  assign diag_hit = p_valid && rd_data[ROW_INDEX_W'(p_idx)];
  assign cyc_now  = cyc || diag_hit;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && last_row) begin
          state_next = ST_PIV_RD;
        end
      end
      ST_PIV_RD:  state_next = ST_PIV_CAP;
      ST_PIV_CAP: state_next = ST_SWEEP;
      ST_SWEEP: begin
        if (idx == n_m1) begin
          state_next = ST_SWEEP_END;
        end
      end
      ST_SWEEP_END: begin
        state_next = (k == n_m1) ? ST_CHECK : ST_PIV_RD;
      end
      ST_CHECK: begin
        if (idx == n_m1) begin
          state_next = ST_CHECK_END;
        end
      end
      ST_CHECK_END: begin
        state_next = cyc_now ? ST_LOAD : ST_EMIT;
      end
      ST_EMIT: begin
        if (idx == n_m1) begin
          state_next = ST_EMIT_END;
        end
      end
      ST_EMIT_END: state_next = ST_LOAD;
      default:     state_next = ST_LOAD;
    endcase
  end

  // Memory accesses. During a sweep the row read in the previous cycle is
  // written back in the same cycle as the next row is read, so the two
  // addresses always differ. The end-of-pass state lets the last write land
  // before the next pivot row is read.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_idx;
    wr_data = rd_data | pivot;
    rd_en   = 1'b0;
    rd_addr = idx[IDX_W-1:0];
    case (state)
      ST_LOAD: begin
        wr_en   = accept;
        wr_addr = rows_loaded[IDX_W-1:0];
        wr_data = row_bits & col_mask;
      end
      ST_PIV_RD: begin
        rd_en   = 1'b1;
        rd_addr = k[IDX_W-1:0];
      end
      ST_SWEEP: begin
        rd_en = 1'b1;
        wr_en = p_valid && rd_data[k_bit];
      end
      ST_SWEEP_END: begin
        wr_en = p_valid && rd_data[k_bit];
      end
      ST_CHECK, ST_EMIT: begin
        rd_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  pcc_row_mem #(
    .DEPTH  (MAX_ITEMS),
    .ADDR_W (IDX_W),
    .DATA_W (ROW_W)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_LOAD;
      item_count  <= COUNT_RESET;
      rows_loaded <= '0;
      idx         <= '0;
      k           <= '0;
      p_valid     <= 1'b0;
      cyc         <= 1'b0;
      done        <= 1'b0;
    end else begin
      state   <= state_next;
      p_valid <= (state inside {ST_SWEEP, ST_CHECK, ST_EMIT});

      // A result is presented once the check confirms a loop in the graph, or for
      // each row read while emitting.
      done <= ((state == ST_CHECK_END) && cyc_now) ||
              ((state inside {ST_EMIT, ST_EMIT_END}) && p_valid);

      // A configuration write abandons any partly loaded run.
      if (cfg_we) begin
        item_count  <= cfg_data;
        rows_loaded <= '0;
      end else if (accept) begin
        rows_loaded <= last_row ? '0 : rows_loaded + CNT_W'(1);
      end

      if (accept && last_row) begin
        k   <= '0;
        cyc <= 1'b0;
      end

      // Every scan leaves the pointer at zero for the next one.
      if (state inside {ST_SWEEP, ST_CHECK, ST_EMIT}) begin
        idx <= (idx == n_m1) ? '0 : idx + CNT_W'(1);
      end

      if (state == ST_SWEEP_END) begin
        k <= k + CNT_W'(1);
      end

      if ((state == ST_CHECK) && diag_hit) begin
        cyc <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    p_idx <= idx[IDX_W-1:0];
    if (state == ST_PIV_CAP) begin
      pivot <= rd_data;
    end
    if (state == ST_CHECK_END) begin
      row_index   <= '0;
      closed_row  <= '0;
      cycle_found <= 1'b1;
      last_result <= 1'b1;
    end else if (state inside {ST_EMIT, ST_EMIT_END}) begin
      row_index   <= ROW_INDEX_W'(p_idx);
      closed_row  <= rd_data;
      cycle_found <= 1'b0;
      last_result <= (CNT_W'(p_idx) == n_m1);
    end
  end

`ifndef SYNTHESIS
  // A write-back never targets the row being read in the same cycle.
  a_no_same_entry: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("row memory read and write collide on one entry");

  // A cycle result carries a zero row and ends the run.
  a_cycle_result: assert property (@(posedge clk) disable iff (rst)
    (done && cycle_found) |-> (last_result && (closed_row == '0) && (row_index == '0)))
    else $error("malformed cycle result");

  // Results only follow work that kept the block busy.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a run in progress");
`endif

endmodule : precedence_closure_cycle_check
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the precedence closure and cycle check block.
// Rows are sent one per transfer, and a software mirror of the block computes
// the expected closed rows or the single cycle result for each completed
// matrix. The item count is changed between runs at a range of sizes,
// including the clamped values.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import pcc_pkg::*;

  localparam int MAX_ITEMS   = MAX_ITEMS_DEF;
  localparam int ITEM_TARGET = 500;   // rows sent by the random phase and before it
  localparam int MAX_REPORTS = 10;

  // One result as the block should present it.
  typedef struct packed {
    logic [ROW_INDEX_W-1:0] idx;
    logic [ROW_W-1:0]       row;
    logic                   cyc;
    logic                   last;
  } closure_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic [ROW_W-1:0]       row_bits = '0;
  logic                   cfg_we = 1'b0;
  logic [COUNT_W-1:0]     cfg_data = '0;
  logic                   busy;
  logic                   done;
  logic [ROW_INDEX_W-1:0] row_index;
  logic [ROW_W-1:0]       closed_row;
  logic                   cycle_found;
  logic                   last_result;

  // Mirror of the block: its row memory, its load position and its register.
  logic [ROW_W-1:0]       mirror_rows [MAX_ITEMS];
  int                     mirror_loaded = 0;
  logic [COUNT_W-1:0]     mirror_count = COUNT_RESET;

  // Results still owed by the block, oldest first.
  closure_result_t        expected_closure [$];

  // Rows of the next graph that a test sends.
  logic [ROW_W-1:0]       graph_rows [MAX_ITEMS];

  int  errors = 0;
  int  rows_sent = 0;
  int  runs_done = 0;
  int  cyclic_runs = 0;
  int  results_checked = 0;
  int  abandoned_runs = 0;
  bit  quiet_sender = 1'b0;

  always #5 clk = ~clk;

  precedence_closure_cycle_check #(
    .MAX_ITEMS(MAX_ITEMS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .row_bits   (row_bits),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .done       (done),
    .row_index  (row_index),
    .closed_row (closed_row),
    .cycle_found(cycle_found),
    .last_result(last_result)
  );

  // The register value in use: zero acts as one, anything above the memory
  // depth acts as the full depth.
  function automatic int active_count(input logic [COUNT_W-1:0] count);
    int n;
    n = int'(count);
    if (n < 1) n = 1;
    if (n > MAX_ITEMS) n = MAX_ITEMS;
    return n;
  endfunction

  function automatic logic [ROW_W-1:0] column_mask(input int n);
    if (n >= ROW_W) return '1;
    return (64'd1 << n) - 64'd1;
  endfunction

  // Called for every accepted row. Stores the row, and when it completes the
  // matrix, runs a Warshall sweep and queues whatever the block must report.
  function automatic void predict_closure(input logic [ROW_W-1:0] row);
    int              n;
    logic            cyclic;
    closure_result_t res;
    n = active_count(mirror_count);
    if (mirror_loaded >= n) mirror_loaded = 0;
    mirror_rows[mirror_loaded] = row & column_mask(n);
    mirror_loaded++;
    if (mirror_loaded < n) return;
    mirror_loaded = 0;
    // Every row that reaches the pivot inherits everything the pivot reaches.
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) begin
        if (mirror_rows[i][k]) mirror_rows[i] = mirror_rows[i] | mirror_rows[k];
      end
    end
    // A closed row that reaches itself means the graph has a directed cycle.
    cyclic = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (mirror_rows[i][i]) cyclic = 1'b1;
    end
    runs_done++;
    if (cyclic) begin
      cyclic_runs++;
      res.idx  = '0;
      res.row  = '0;
      res.cyc  = 1'b1;
      res.last = 1'b1;
      expected_closure.insert(expected_closure.size(), res);
    end else begin
      for (int i = 0; i < n; i++) begin
        res.idx  = ROW_INDEX_W'(i);
        res.row  = mirror_rows[i];
        res.cyc  = 1'b0;
        res.last = (i == n - 1);
        expected_closure.insert(expected_closure.size(), res);
      end
    end
  endfunction

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Most runs are small, since the closure time grows with the square of the
  // size; a few use the full depth or one of the clamped register values.
  function automatic logic [COUNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 58) return COUNT_W'($urandom_range(1, 8));
    if (r < 83) return COUNT_W'($urandom_range(9, 20));
    if (r < 91) return COUNT_W'($urandom_range(21, 63));
    if (r < 94) return COUNT_W'(64);
    if (r < 96) return '0;
    return COUNT_W'($urandom_range(65, 127));
  endfunction

  // Builds a random graph of n items in graph_rows. Most graphs are acyclic
  // (edges only go forward in a shuffled order), some get one extra edge that
  // may close a loop, and some are plain noise. Bits above the item count
  // are often filled with junk, which the block has to ignore.
  function automatic void make_graph(input int n);
    int               order [MAX_ITEMS];
    int               kind;
    int               density;
    int               pick;
    int               tmp;
    logic [ROW_W-1:0] mask;
    kind    = $urandom_range(0, 99);
    density = $urandom_range(0, 3);
    mask    = column_mask(n);
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      pick        = $urandom_range(0, i);
      tmp         = order[i];
      order[i]    = order[pick];
      order[pick] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      graph_rows[i] = '0;
      if (kind >= 85) begin
        graph_rows[i] = {$urandom, $urandom};
      end else begin
        for (int j = 0; j < n; j++) begin
          if (order[j] > order[i] && $urandom_range(0, 7) < (1 << density) - 1 + (density == 0))
            graph_rows[i][j] = 1'b1;
        end
      end
      if (n < ROW_W && $urandom_range(0, 1) == 1)
        graph_rows[i] = graph_rows[i] | ({$urandom, $urandom} & ~mask);
    end
    if (kind >= 70 && kind < 85) begin
      pick = $urandom_range(0, n - 1);
      graph_rows[pick][$urandom_range(0, n - 1)] = 1'b1;
    end
  endfunction

  // One row transfer. A row that follows at once keeps start high, so start
  // only ever gets one assignment per clock edge.
  task automatic send_row(input logic [ROW_W-1:0] row);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    row_bits <= row;
    do @(posedge clk); while (busy);
    predict_closure(row);
    rows_sent++;
  endtask

  task automatic send_graph(input int count);
    for (int i = 0; i < count; i++) send_row(graph_rows[i]);
  endtask

  // Holds the sender back until every owed result has come out and the
  // block is back to taking rows.
  task automatic drain();
    start <= 1'b0;
    while (expected_closure.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Register writes happen only on an idle block. A write also throws away
  // any rows of a partly loaded matrix.
  task automatic set_count(input logic [COUNT_W-1:0] count);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    cfg_we        <= 1'b0;
    mirror_count  = count;
    mirror_loaded = 0;
  endtask

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Results cannot be held off, so every cycle with done high is a transfer
  // and is checked against the oldest expectation.
  always @(posedge clk) begin : check_results
    closure_result_t want;
    if (!rst && done) begin
      if (expected_closure.size() == 0) begin
        report_error($sformatf("unexpected result idx=%0d row=%h cyc=%b last=%b",
                               row_index, closed_row, cycle_found, last_result));
      end else begin
        want = expected_closure.pop_front();
        results_checked++;
        if (row_index !== want.idx || closed_row !== want.row ||
            cycle_found !== want.cyc || last_result !== want.last) begin
          report_error($sformatf(
            "expected idx=%0d row=%h cyc=%b last=%b, got idx=%0d row=%h cyc=%b last=%b",
            want.idx, want.row, want.cyc, want.last,
            row_index, closed_row, cycle_found, last_result));
        end
      end
    end
  end

  // The reset count of 64 with the densest acyclic matrix: every item
  // precedes every later one, so row 0 is nearly all ones and the last row
  // is empty, and the closure equals the input.
  task automatic test_default_count();
    for (int i = 0; i < MAX_ITEMS; i++) graph_rows[i] = ~64'd0 << (i + 1);
    send_graph(MAX_ITEMS);
  endtask

  // One item: a zero row, a self loop, an all-ones row (its bit 0 makes a
  // loop) and one whose only set bits are out of range. A count of zero must
  // act like one.
  task automatic test_single_item();
    set_count(COUNT_W'(1));
    send_row('0);
    send_row(64'd1);
    send_row('1);
    send_row(~64'd1);
    set_count('0);
    send_row(64'd1);
    send_row(64'h8000_0000_0000_0000);
  endtask

  // Two and three items: a chain, a two-item loop, junk in the upper bits,
  // a three-item chain whose closure adds an edge and a three-item loop.
  task automatic test_small_graphs();
    set_count(COUNT_W'(2));
    send_row(64'd2);
    send_row(64'd0);
    send_row(64'd2);
    send_row(64'd1);
    send_row(64'hFFFF_FFFF_FFFF_FFF2);
    send_row(64'hFFFF_FFFF_FFFF_FFFC);
    set_count(COUNT_W'(3));
    send_row(64'd2);
    send_row(64'd4);
    send_row(64'd0);
    send_row(64'd2);
    send_row(64'd4);
    send_row(64'd1);
  endtask

  // Two rows of a three-item matrix, then a register write: the next three
  // rows must form a fresh matrix.
  task automatic test_abandoned_run();
    set_count(COUNT_W'(3));
    send_row(64'd1);
    send_row(64'd1);
    abandoned_runs++;
    set_count(COUNT_W'(3));
    send_row(64'd2);
    send_row(64'd4);
    send_row(64'd0);
  endtask

  // Random matrices until the row budget is spent. Counts change between
  // some runs; other runs follow straight on, so start waits on busy. The
  // first run uses the largest register value, which clamps to the depth.
  task automatic test_random_runs();
    int  n;
    int  part;
    bit  force_write;
    bit  first_write;
    force_write = 1'b1;
    first_write = 1'b1;
    while (rows_sent < ITEM_TARGET) begin
      if (force_write) begin
        set_count(first_write ? COUNT_W'(127) : pick_count());
        force_write = 1'b0;
        first_write = 1'b0;
      end else if ($urandom_range(0, 9) < 4) begin
        set_count(pick_count());
      end else if ($urandom_range(0, 9) == 0) begin
        drain();
      end
      quiet_sender = ($urandom_range(0, 3) == 0);
      n = active_count(mirror_count);
      make_graph(n);
      if (n > 1 && $urandom_range(0, 99) < 8) begin
        // Leave the matrix unfinished; the forced write discards it.
        part = $urandom_range(1, n - 1);
        send_graph(part);
        abandoned_runs++;
        force_write = 1'b1;
      end else begin
        send_graph(n);
      end
    end
    quiet_sender = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_default_count();
    test_single_item();
    test_small_graphs();
    test_abandoned_run();
    test_random_runs();
    // Let the last closure finish and give stray results time to show up.
    drain();
    repeat (16) @(posedge clk);
    $display("Sent %0d rows forming %0d complete matrices (%0d cyclic, %0d abandoned).",
             rows_sent, runs_done, cyclic_runs, abandoned_runs);
    $display("Checked %0d results; %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Far beyond the slowest correct run, even if every run used a full-size
  // matrix with the longest sender pauses.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding.", expected_closure.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule : testbench
`default_nettype wire
